// ----- hw/rtl/hst_pkg.sv -----
// Package for the hashed slot table: sizes, payload structs, codes and the
// controller state type. Depends on nothing; every other file uses it.
`default_nettype none

package hst_pkg;

	// Physical slots in the value store.
	localparam int TABLE_SLOTS = 1024;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	// Fixed field widths.
	localparam int CNT_W   = 11;
	localparam int HASH_W  = 16;
	localparam int VAL_W   = 64;
	localparam int KEY_W   = 64;
	localparam int CFG_IDX_W = 1;

	// Actions.
	localparam logic [1:0] ACT_PUT    = 2'd0;
	localparam logic [1:0] ACT_GET    = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_COLLISION = 2'd1;
	localparam logic [1:0] STAT_ZERO      = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE    = 1'd1;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key_low;
		logic [KEY_W-1:0] key_high;
		logic [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] value_out;
		logic [1:0]       status;
	} rsp_t;

	// One request to the value store.
	typedef struct packed {
		logic              re;
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [VAL_W-1:0]  wdata;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_WIPE,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_READ,
		S_DECIDE,
		S_CLEAR,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hst_mix.sv -----
// Key hash unit: one shared subtract/xor/shift datapath steps through two
// mix rounds, one line per cycle, key addition between. Depends on hst_pkg.
`default_nettype none

module hst_mix (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [hst_pkg::KEY_W-1:0] key_low,
	input  wire logic [hst_pkg::KEY_W-1:0] key_high,
	output logic                           done,
	output logic [hst_pkg::HASH_W-1:0]     hash
);

	localparam logic [31:0] HASH_SEED = 32'h0000_9e37;
	localparam logic [31:0] HASH_INIT = 32'd131;
	localparam logic [31:0] KEY_BYTES = 32'd16;
	localparam logic [3:0]  LAST_STEP = 4'd8;

	// One line of the mix: target minus the other two, then xor with a
	// shifted copy of the value subtracted last.
	function automatic logic [31:0] mix_line(input logic [3:0] step,
		input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		logic [31:0] d;
		logic [31:0] s;
		d = x - y - z;
		case (step)
			4'd0:    s = z >> 13;
			4'd1:    s = z << 8;
			4'd2:    s = z >> 13;
			4'd3:    s = z >> 12;
			4'd4:    s = z << 16;
			4'd5:    s = z >> 5;
			4'd6:    s = z >> 3;
			4'd7:    s = z << 10;
			default: s = z >> 15;
		endcase
		return d ^ s;
	endfunction

	logic [31:0] x_q, y_q, z_q;
	logic [3:0]  step_q;
	logic        busy_q, mid_q, round_q, done_q;
	logic [31:0] line_val;

	assign line_val = mix_line(step_q, x_q, y_q, z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			mid_q   <= 1'b0;
			round_q <= 1'b0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				mid_q   <= 1'b0;
				round_q <= 1'b0;
				step_q  <= '0;
			end else if (mid_q) begin
				mid_q   <= 1'b0;
				round_q <= 1'b1;
				step_q  <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					step_q <= '0;
					if (round_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						mid_q <= 1'b1;
					end
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	// The registers rotate so that the next target is always in x_q; after
	// nine lines a, b, c are back in x_q, y_q, z_q.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= HASH_SEED + key_low[31:0];
			y_q <= HASH_SEED + key_low[63:32];
			z_q <= HASH_INIT + key_high[31:0];
		end else if (mid_q) begin
			x_q <= x_q + key_high[63:32];
			z_q <= z_q + KEY_BYTES;
		end else if (busy_q) begin
			x_q <= y_q;
			y_q <= z_q;
			z_q <= line_val;
		end
	end

	assign done = done_q;
	assign hash = z_q[hst_pkg::HASH_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/hst_mod.sv -----
// Restoring remainder unit: one dividend bit per cycle, most significant first.
// Depends on hst_pkg.
`default_nettype none

module hst_mod (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [hst_pkg::HASH_W-1:0] dividend,
	input  wire logic [hst_pkg::CNT_W-1:0]  divisor,
	output logic                           done,
	output logic [hst_pkg::CNT_W-1:0]      rem
);

	localparam int CNT_BITS = $clog2(hst_pkg::HASH_W);

	logic [hst_pkg::HASH_W-1:0] quo_q;
	logic [hst_pkg::CNT_W-1:0]  rem_q, div_q;
	logic [CNT_BITS-1:0]        cnt_q;
	logic                       busy_q, done_q;
	logic [hst_pkg::CNT_W:0]    trial;
	logic [hst_pkg::CNT_W:0]    trial_sub;

	assign trial     = {rem_q, quo_q[hst_pkg::HASH_W-1]};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(hst_pkg::HASH_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it fits CNT_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[hst_pkg::HASH_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial_sub[hst_pkg::CNT_W-1:0];
			end else begin
				rem_q <= trial[hst_pkg::CNT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hst_mem.sv -----
// Slot value store: single port, one read and/or write per cycle, registered
// read data. Depends on hst_pkg.
`default_nettype none

module hst_mem (
	input  wire logic                     clk,
	input  wire hst_pkg::mem_req_t        req,
	output logic [hst_pkg::VAL_W-1:0]     rdata
);

	logic [hst_pkg::VAL_W-1:0] mem [hst_pkg::TABLE_SLOTS];
	logic [hst_pkg::VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hashed_slot_table.sv -----
// Hashed slot table top level: controller, configuration registers and
// result register. Depends on hst_pkg, hst_mix, hst_mod and hst_mem.
//
// Usage:
// A request transaction on req (valid/ready) carries an action, a 16-byte
// key and a value. The key is hashed with a two-round lookup2-style mix,
// reduced modulo the configured slot count, and the selected slot of a
// 1024 x 64 value store is read and possibly written. Exactly one response
// transaction on rsp (valid/ready) follows each request.
// A put, get or delete passes through the mix unit (a load step, two rounds of
// nine mix lines, a key-addition step between them and a done step), the
// bit-serial remainder unit, then a memory read, a decision/write step and
// the load of the response register. Clear writes one slot per cycle and
// then answers. One request is in flight at a time and req_ready is high
// only while idle, which the block reenters at the edge that loads the
// response register.
// After reset the block sweeps zeros through all 1024 slots with req_ready
// low; configuration writes are taken during it.
// The response sits in an output register. If the receiver stalls, the
// block still returns to idle and takes the next request; the following
// response waits in the controller until the register is free.
`default_nettype none

module hashed_slot_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire hst_pkg::req_t                  req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output hst_pkg::rsp_t                       rsp,
	input  wire logic                           cfg_we,
	input  wire logic [hst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hst_pkg::CNT_W-1:0]      cfg_data
);

	localparam logic [hst_pkg::SLOT_W-1:0] LAST_SLOT =
		hst_pkg::SLOT_W'(hst_pkg::TABLE_SLOTS - 1);

	hst_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [hst_pkg::CNT_W-1:0] slot_count_q;
	logic                      replace_q;
	logic [hst_pkg::CNT_W-1:0] slots_eff;

	// Working registers of the current transaction.
	hst_pkg::req_t             item_q;
	logic [hst_pkg::SLOT_W-1:0] idx_q;
	logic [hst_pkg::SLOT_W-1:0] clr_q;
	hst_pkg::rsp_t             res_q;
	hst_pkg::rsp_t             rsp_q;
	logic                      rsp_valid_q;

	// Unit handshakes and the memory request.
	logic                         accept;
	logic                         mix_start, mix_done;
	logic                         mix_busy_q;
	logic [hst_pkg::HASH_W-1:0]   hash;
	logic                         mod_start, mod_done;
	logic [hst_pkg::CNT_W-1:0]    rem;
	hst_pkg::mem_req_t            mem_req;
	logic [hst_pkg::VAL_W-1:0]    mem_rdata;
	logic                         rsp_free;
	logic                         clr_last;
	hst_pkg::rsp_t                decide_res;
	logic                         decide_we;
	logic [hst_pkg::VAL_W-1:0]    decide_wdata;

	assign accept   = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign clr_last = (clr_q == LAST_SLOT);

	// A slot count of zero behaves as one, and any count beyond the store as the
	// full store.
	always_comb begin
		if (slot_count_q == '0) begin
			slots_eff = hst_pkg::CNT_W'(1);
		end else if (32'(slot_count_q) > hst_pkg::TABLE_SLOTS) begin
			slots_eff = hst_pkg::CNT_W'(hst_pkg::TABLE_SLOTS);
		end else begin
			slots_eff = slot_count_q;
		end
	end

	hst_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mix_start),
		.key_low  (item_q.key_low),
		.key_high (item_q.key_high),
		.done     (mix_done),
		.hash     (hash)
	);

	hst_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (hash),
		.divisor  (slots_eff),
		.done     (mod_done),
		.rem      (rem)
	);

	hst_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// The slot decision once the stored value is back from memory.
	always_comb begin
		decide_res   = '{value_out: '0, status: hst_pkg::STAT_OK};
		decide_we    = 1'b0;
		decide_wdata = item_q.item_value;
		case (item_q.action)
			hst_pkg::ACT_PUT: begin
				if (item_q.item_value == '0) begin
					decide_res.status = hst_pkg::STAT_ZERO;
				end else if (mem_rdata != '0 && !replace_q) begin
					decide_res.status = hst_pkg::STAT_COLLISION;
				end else begin
					decide_res.value_out = mem_rdata;
					decide_we            = 1'b1;
				end
			end
			hst_pkg::ACT_GET: begin
				decide_res.value_out = mem_rdata;
			end
			hst_pkg::ACT_DELETE: begin
				decide_we    = 1'b1;
				decide_wdata = '0;
			end
			default: begin
				decide_we = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			hst_pkg::S_WIPE: begin
				if (clr_last) state_d = hst_pkg::S_IDLE;
			end
			hst_pkg::S_IDLE: begin
				if (accept) begin
					if (req.action == hst_pkg::ACT_CLEAR) begin
						state_d = hst_pkg::S_CLEAR;
					end else begin
						state_d = hst_pkg::S_HASH;
					end
				end
			end
			hst_pkg::S_HASH: begin
				if (mix_done) state_d = hst_pkg::S_MOD;
			end
			hst_pkg::S_MOD: begin
				if (mod_done) state_d = hst_pkg::S_READ;
			end
			hst_pkg::S_READ: begin
				state_d = hst_pkg::S_DECIDE;
			end
			hst_pkg::S_DECIDE: begin
				state_d = hst_pkg::S_DONE;
			end
			hst_pkg::S_CLEAR: begin
				if (clr_last) state_d = hst_pkg::S_DONE;
			end
			hst_pkg::S_DONE: begin
				if (rsp_free) state_d = hst_pkg::S_IDLE;
			end
			default: begin
				state_d = hst_pkg::S_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		req_ready     = 1'b0;
		mix_start     = 1'b0;
		mod_start     = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.addr  = idx_q;
		mem_req.wdata = decide_wdata;
		case (state_q)
			hst_pkg::S_WIPE, hst_pkg::S_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = clr_q;
				mem_req.wdata = '0;
			end
			hst_pkg::S_IDLE: begin
				req_ready = 1'b1;
			end
			hst_pkg::S_HASH: begin
				mod_start = mix_done;
			end
			hst_pkg::S_READ: begin
				mem_req.re = 1'b1;
			end
			hst_pkg::S_DECIDE: begin
				mem_req.we = decide_we;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
		// The mix unit starts in the cycle after acceptance, once item_q holds
		// the key.
		if (state_q == hst_pkg::S_HASH && !mix_busy_q) mix_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hst_pkg::S_WIPE;
			clr_q        <= '0;
			mix_busy_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			slot_count_q <= hst_pkg::CNT_W'(hst_pkg::TABLE_SLOTS);
			replace_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					hst_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_data;
					hst_pkg::CFG_REPLACE:    replace_q    <= cfg_data[0];
					default:                 replace_q    <= replace_q;
				endcase
			end

			if (state_q == hst_pkg::S_WIPE || state_q == hst_pkg::S_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end

			if (state_q == hst_pkg::S_HASH) begin
				mix_busy_q <= 1'b1;
			end else begin
				mix_busy_q <= 1'b0;
			end

			if (state_q == hst_pkg::S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
			res_q  <= '{value_out: '0, status: hst_pkg::STAT_OK};
		end
		if (state_q == hst_pkg::S_MOD && mod_done) begin
			idx_q <= hst_pkg::SLOT_W'(rem);
		end
		if (state_q == hst_pkg::S_DECIDE) begin
			res_q <= decide_res;
		end
		if (state_q == hst_pkg::S_DONE && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hst_checker.sv -----
// Port-level checker for the hashed slot table, bound to the top level.
// Depends on hst_pkg and hashed_slot_table.
`default_nettype none

module hst_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	input  wire logic                           req_ready,
	input  wire logic                           rsp_valid,
	input  wire logic                           rsp_ready,
	input  wire hst_pkg::rsp_t                  rsp
);

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// One transaction at a time: the block goes busy right after accepting.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// A new response is only produced out of a busy cycle.
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without work");

	// Status is one of the defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == hst_pkg::STAT_OK ||
			rsp.status == hst_pkg::STAT_COLLISION ||
			rsp.status == hst_pkg::STAT_ZERO))
		else $error("undefined status code");

	// Refused puts return no value.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != hst_pkg::STAT_OK |-> rsp.value_out == '0)
		else $error("refused put returned a value");

endmodule

bind hashed_slot_table hst_checker u_hst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// ----- bench/tb_hashed_slot_table.sv -----
// Self-checking testbench for the hashed slot table, with a shadow copy of the
// value store that predicts every response. Depends on hst_pkg and on the
// hashed_slot_table top level.

module tb_hashed_slot_table;
	timeunit 1ns;
	timeprecision 1ps;

	// The random part is split into chunks, each under its own register setting
	// and idle profile.
	localparam int RANDOM_CHUNKS = 6;
	localparam int CHUNK_ITEMS   = 330;
	// The long receiver hold-off starts once this many responses have been
	// taken, which falls within the last chunk, where nobody idles.
	localparam int HOLD_AFTER_RSP = 1800;
	localparam int HOLD_CYCLES    = 600;
	// A little more than the request latency.
	localparam int DRAIN_CYCLES   = 50;
	localparam int KEY_POOL       = 12;
	localparam int POOL_W         = $clog2(KEY_POOL);

	// Shadow of the value store. It keeps the same contents and registers as
	// the block, works out the response of each accepted request in order and
	// holds the responses still to come.
	class slot_table_shadow;
		logic [hst_pkg::VAL_W-1:0] slot_mem [hst_pkg::TABLE_SLOTS];
		logic [hst_pkg::CNT_W-1:0] slot_count;
		bit                        replace;
		hst_pkg::rsp_t             awaited_rsp [$];
		int unsigned               errors;
		int unsigned               n_put, n_get, n_delete, n_clear;
		int unsigned               n_collision, n_zero, n_hit;

		function new();
			foreach (slot_mem[i])
				slot_mem[i] = '0;
			slot_count = hst_pkg::CNT_W'(hst_pkg::TABLE_SLOTS);
			replace = 1'b0;
		endfunction

		function void set_config(logic [hst_pkg::CNT_W-1:0] count, bit repl);
			slot_count = count;
			replace = repl;
		endfunction

		function void mix_round(inout logic [31:0] a, inout logic [31:0] b,
				inout logic [31:0] c);
			a = a - b; a = a - c; a = a ^ (c >> 13);
			b = b - c; b = b - a; b = b ^ (a << 8);
			c = c - a; c = c - b; c = c ^ (b >> 13);
			a = a - b; a = a - c; a = a ^ (c >> 12);
			b = b - c; b = b - a; b = b ^ (a << 16);
			c = c - a; c = c - b; c = c ^ (b >> 5);
			a = a - b; a = a - c; a = a ^ (c >> 3);
			b = b - c; b = b - a; b = b ^ (a << 10);
			c = c - a; c = c - b; c = c ^ (b >> 15);
		endfunction

		function logic [hst_pkg::HASH_W-1:0] lookup2_hash(logic [hst_pkg::KEY_W-1:0] lo,
				logic [hst_pkg::KEY_W-1:0] hi);
			logic [31:0] a, b, c;
			a = 32'h9e37 + lo[31:0];
			b = 32'h9e37 + lo[63:32];
			c = 32'd131 + hi[31:0];
			mix_round(a, b, c);
			c = c + 32'd16;
			a = a + hi[63:32];
			mix_round(a, b, c);
			return c[hst_pkg::HASH_W-1:0];
		endfunction

		// A slot count of zero behaves as one; anything above the physical size
		// behaves as the physical size.
		function logic [hst_pkg::SLOT_W-1:0] key_slot(logic [hst_pkg::KEY_W-1:0] lo,
				logic [hst_pkg::KEY_W-1:0] hi);
			int unsigned n, h;
			n = 32'(slot_count);
			if (n == 0)
				n = 1;
			if (n > hst_pkg::TABLE_SLOTS)
				n = hst_pkg::TABLE_SLOTS;
			h = 32'(lookup2_hash(lo, hi));
			return hst_pkg::SLOT_W'(h % n);
		endfunction

		function void accept_request(hst_pkg::req_t r);
			hst_pkg::rsp_t             exp;
			logic [hst_pkg::SLOT_W-1:0] idx;
			exp.value_out = '0;
			exp.status = hst_pkg::STAT_OK;
			idx = key_slot(r.key_low, r.key_high);
			case (r.action)
			hst_pkg::ACT_PUT: begin
				n_put++;
				if (r.item_value == '0) begin
					exp.status = hst_pkg::STAT_ZERO;
					n_zero++;
				end else if (slot_mem[idx] != '0 && !replace) begin
					exp.status = hst_pkg::STAT_COLLISION;
					n_collision++;
				end else begin
					exp.value_out = slot_mem[idx];
					slot_mem[idx] = r.item_value;
				end
			end
			hst_pkg::ACT_GET: begin
				n_get++;
				exp.value_out = slot_mem[idx];
				if (slot_mem[idx] != '0)
					n_hit++;
			end
			hst_pkg::ACT_DELETE: begin
				n_delete++;
				slot_mem[idx] = '0;
			end
			default: begin
				n_clear++;
				foreach (slot_mem[i])
					slot_mem[i] = '0;
			end
			endcase
			awaited_rsp.push_back(exp);
		endfunction

		function void check_response(hst_pkg::rsp_t got);
			hst_pkg::rsp_t exp;
			if (awaited_rsp.size() == 0) begin
				$error("unexpected response: value_out %h, status %0d",
					got.value_out, got.status);
				errors++;
				return;
			end
			exp = awaited_rsp.pop_front();
			if (got.value_out !== exp.value_out) begin
				$error("value_out: expected %h, got %h", exp.value_out, got.value_out);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	// Every input of the block holds a known value from time zero.
	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              req_valid = 1'b0;
	hst_pkg::req_t                     req       = '0;
	logic                              rsp_ready = 1'b0;
	logic                              cfg_we    = 1'b0;
	logic [hst_pkg::CFG_IDX_W-1:0]     cfg_index = hst_pkg::CFG_SLOT_COUNT;
	logic [hst_pkg::CNT_W-1:0]         cfg_data  = '0;
	logic                              req_ready;
	logic                              rsp_valid;
	hst_pkg::rsp_t                     rsp;

	slot_table_shadow shadow = new();

	// Idle rates in percent, changed by the stimulus between chunks.
	int unsigned req_gap_pct = 17;
	int unsigned rsp_gap_pct = 78;
	int unsigned n_settings  = 0;

	// Recently used keys. Drawing most keys from this small pool makes gets
	// find stored values and puts run into occupied slots.
	logic [hst_pkg::KEY_W-1:0] pool_low  [KEY_POOL];
	logic [hst_pkg::KEY_W-1:0] pool_high [KEY_POOL];

	hashed_slot_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs. The slowest plausible run is well
	// under a fifth of this.
	initial begin
		#(10_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// Receiver side. Outputs are sampled just after the rising edge, before the
	// block's own updates for that edge land, so each transaction is seen with
	// the values that were on the wires at the edge.
	initial begin : rsp_side
		int unsigned rsp_seen;
		int unsigned hold_left;
		rsp_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				shadow.check_response(rsp);
				rsp_seen++;
				// Refuse responses for a long while so that the output register
				// and the parked response fill up and the request side stalls.
				if (rsp_seen == HOLD_AFTER_RSP)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_gap_pct);
			end
		end
	end

	// Offers one request and returns in the time step of the edge that accepts
	// it. Valid is left high so that a following request can go out back to
	// back; whoever comes next lowers it.
	task automatic send_request(input hst_pkg::req_t item);
		while ($urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		shadow.accept_request(item);
	endtask

	task automatic send_op(input logic [1:0] action,
			input logic [hst_pkg::KEY_W-1:0] lo,
			input logic [hst_pkg::KEY_W-1:0] hi,
			input logic [hst_pkg::VAL_W-1:0] val);
		hst_pkg::req_t item;
		item.action = action;
		item.key_low = lo;
		item.key_high = hi;
		item.item_value = val;
		send_request(item);
	endtask

	// Registers only change once every request has been answered, so the block is idle
	// or, on the first call, still wiping its store. Both registers are written
	// on consecutive edges with the write enable held high.
	task automatic configure(input logic [hst_pkg::CNT_W-1:0] count, input bit repl);
		req_valid <= 1'b0;
		while (shadow.awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= hst_pkg::CFG_SLOT_COUNT;
		cfg_data <= count;
		@(posedge clk);
		cfg_index <= hst_pkg::CFG_REPLACE;
		cfg_data <= {{(hst_pkg::CNT_W-1){1'b0}}, repl};
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.set_config(count, repl);
		n_settings++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic hst_pkg::req_t random_request();
		hst_pkg::req_t     r;
		int unsigned       pick;
		logic [POOL_W-1:0] i;
		pick = $urandom_range(99);
		if (pick < 45)
			r.action = hst_pkg::ACT_PUT;
		else if (pick < 77)
			r.action = hst_pkg::ACT_GET;
		else if (pick < 99)
			r.action = hst_pkg::ACT_DELETE;
		else
			r.action = hst_pkg::ACT_CLEAR;

		pick = $urandom_range(99);
		i = POOL_W'($urandom_range(KEY_POOL - 1));
		if (pick < 10) begin
			// Retire a pool entry in favor of a fresh key.
			pool_low[i] = rand64();
			pool_high[i] = rand64();
		end
		if (pick < 75) begin
			r.key_low = pool_low[i];
			r.key_high = pool_high[i];
		end else if (pick < 80) begin
			r.key_low = '0;
			r.key_high = '0;
		end else if (pick < 85) begin
			r.key_low = '1;
			r.key_high = '1;
		end else begin
			r.key_low = rand64();
			r.key_high = rand64();
		end

		pick = $urandom_range(99);
		if (pick < 5)
			r.item_value = '0;
		else if (pick < 8)
			r.item_value = '1;
		else if (pick < 20)
			r.item_value = hst_pkg::VAL_W'($urandom_range(1, 255));
		else
			r.item_value = rand64();
		return r;
	endfunction

	initial begin : stimulus
		logic [hst_pkg::KEY_W-1:0] ka_lo, ka_hi;
		ka_lo = 64'h0123_4567_89ab_cdef;
		ka_hi = 64'hfedc_ba98_7654_3210;
		foreach (pool_low[i]) begin
			pool_low[i] = rand64();
			pool_high[i] = rand64();
		end

		// Reset is held from time zero, then released. The block then wipes its store with the request
		// side closed; register writes are taken during the wipe.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		configure(hst_pkg::CNT_W'(hst_pkg::TABLE_SLOTS), 1'b0);

		// Directed part, full table, collisions refused. A zero value on put is
		// rejected, a second put to an occupied slot is refused, then gets and a delete
		// with the all-zero and all-one keys, and a clear.
		send_op(hst_pkg::ACT_PUT, '0, '0, '0);
		send_op(hst_pkg::ACT_PUT, '0, '0, '1);
		send_op(hst_pkg::ACT_PUT, '0, '0, 64'd5);
		send_op(hst_pkg::ACT_GET, '0, '0, '0);
		send_op(hst_pkg::ACT_PUT, '1, '1, 64'h8000_0000_0000_0001);
		send_op(hst_pkg::ACT_GET, '1, '1, '1);
		send_op(hst_pkg::ACT_DELETE, '0, '0, 64'd9);
		send_op(hst_pkg::ACT_GET, '0, '0, '0);
		send_op(hst_pkg::ACT_GET, ka_lo, ka_hi, '0);
		send_op(hst_pkg::ACT_CLEAR, ka_lo, ka_hi, '1);
		send_op(hst_pkg::ACT_GET, '1, '1, '0);

		// A slot count above the physical size acts as the full table; with
		// replacement on, a put to an occupied slot returns the old value.
		configure('1, 1'b1);
		send_op(hst_pkg::ACT_PUT, '1, '1, 64'hdead_beef_0000_0001);
		send_op(hst_pkg::ACT_PUT, '1, '1, 64'h0000_0001_cafe_f00d);
		send_op(hst_pkg::ACT_PUT, '0, '0, 64'd3);

		// A slot count of zero acts as one, so every key lands in slot zero.
		configure('0, 1'b0);
		send_op(hst_pkg::ACT_PUT, ka_lo, ka_hi, 64'd77);
		send_op(hst_pkg::ACT_GET, ka_hi, ka_lo, '0);
		send_op(hst_pkg::ACT_PUT, ka_hi, ka_lo, '0);
		send_op(hst_pkg::ACT_DELETE, '1, '0, '0);
		send_op(hst_pkg::ACT_CLEAR, '0, '1, '0);

		configure(hst_pkg::CNT_W'(1), 1'b1);
		send_op(hst_pkg::ACT_PUT, ka_lo, ka_hi, 64'd11);
		send_op(hst_pkg::ACT_PUT, '1, '1, 64'd12);
		send_op(hst_pkg::ACT_GET, '0, '0, '0);

		// Random part. Each chunk gets its own register setting; the first two idle mostly
		// on the receiver side, the next two on the sender side, the last two run flat out.
		for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
			case (chunk)
			0: configure(hst_pkg::CNT_W'(hst_pkg::TABLE_SLOTS), 1'b0);
			1: configure(hst_pkg::CNT_W'($urandom_range(2, 16)), 1'b1);
			2: configure('1, 1'b1);
			3: configure('0, 1'b0);
			4: configure(hst_pkg::CNT_W'($urandom_range(17, 1023)),
				1'($urandom_range(1)));
			default: configure(hst_pkg::CNT_W'($urandom_range(1, 64)), 1'b0);
			endcase
			req_gap_pct = (chunk < 2) ? 17 : (chunk < 4) ? 78 : 0;
			rsp_gap_pct = (chunk < 2) ? 78 : (chunk < 4) ? 17 : 0;
			repeat (CHUNK_ITEMS)
				send_request(random_request());
		end

		// Let everything drain, then give the block time to show any response
		// that nobody asked for.
		req_valid <= 1'b0;
		while (shadow.awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d puts, %0d gets, %0d deletes and %0d clears under %0d settings.",
			shadow.n_put, shadow.n_get, shadow.n_delete, shadow.n_clear, n_settings);
		$display("Collisions refused: %0d, zero-value puts: %0d, gets of stored values: %0d.",
			shadow.n_collision, shadow.n_zero, shadow.n_hit);
		if (shadow.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- hashed_slot_table.f -----
hw/rtl/hst_pkg.sv
hw/rtl/hst_mix.sv
hw/rtl/hst_mod.sv
hw/rtl/hst_mem.sv
hw/rtl/hashed_slot_table.sv
hw/rtl/hst_checker.sv
bench/tb_hashed_slot_table.sv
